@@ rtl/ddalr_pkg.sv @@
// shared types and codes for the dda line rasterizer
`default_nettype none

package ddalr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIV_X = 3'b010,
    ST_DIV_Y = 3'b100
  } state_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

endpackage

`default_nettype wire

@@ rtl/ddalr_div.sv @@
// serial restoring divider, one quotient bit per cycle
`default_nettype none

module ddalr_div #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  wire [COORD_BITS+FRAC_BITS-1:0]  num,
  input  wire [COORD_BITS-1:0]            den,
  output logic                            done,
  output logic [FRAC_BITS:0]              quo
);

  localparam int NW = COORD_BITS + FRAC_BITS;
  localparam int CW = $clog2(NW);

  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [NW-1:0]         quo_r, quo_nxt;
  logic [COORD_BITS-1:0] den_r, den_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS+1:0] diff;
  logic                  ge;

  always_comb begin
    trial = {rem_r, quo_r[NW-1]};
    diff  = {1'b0, trial} - {2'b00, den_r};
    ge    = ~diff[COORD_BITS+1];
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r[FRAC_BITS:0];

endmodule

`default_nettype wire

@@ rtl/dda_line_rasterizer.sv @@
// dda line rasterizer top level: line setup sequencer, step accumulators, result register
//
//  channel | dir | tdata (low bit up)                     | tlast | tuser
//  in_     | in  | start_x, start_y, end_x, end_y         | -     | op
//  out_    | out | px, py, zero fill                      | last  | none
//
// a step item or a start item with equal endpoints leaves the sequencer idle;
// any other start item emits its first point at once, then the shared divider
// computes the x step, then the y step; in_tready stays low until both are done
// reset clears the line and the result valid flag; a held result blocks new items
`default_nettype none

module dda_line_rasterizer #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire [((4*COORD_BITS+7)/8)*8-1:0]     in_tdata,  // start_x, start_y, end_x, end_y
  input  wire [0:0]                            in_tuser,  // op
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    out_tdata, // px, py
  output logic                                 out_tlast,
  output logic [0:0]                           out_tuser  // none
);

  localparam int CB    = COORD_BITS;
  localparam int FB    = FRAC_BITS;
  localparam int AW    = CB + FB + 1;
  localparam int SW    = FB + 2;
  localparam int OUT_W = ((2*CB+7)/8)*8;

  ddalr_pkg::state_t   state_r, state_nxt;
  logic                div_start;
  logic                div_done;

  logic [AW-1:0] x_acc_r, x_acc_nxt, y_acc_r, y_acc_nxt;
  logic [SW-1:0] x_step_r, x_step_nxt, y_step_r, y_step_nxt;
  logic [CB-1:0] steps_left_r, steps_left_nxt;
  logic          active_r, active_nxt;
  logic [CB-1:0] ady_r, ady_nxt;
  logic          xneg_r, xneg_nxt, yneg_r, yneg_nxt;

  logic          ovalid_r, ovalid_nxt;
  logic [CB-1:0] px_r, px_nxt, py_r, py_nxt;
  logic          last_r, last_nxt, none_r, none_nxt;

  logic [CB-1:0]    sx, sy, ex, ey;
  logic [CB:0]      dx, dy;
  logic [CB-1:0]    adx, ady, steps;
  logic             accept;
  logic [AW-1:0]    x_sum, y_sum, x_rnd, y_rnd;
  logic [CB+FB-1:0] div_num;
  logic [CB-1:0]    div_den;
  logic [FB:0]      quo;
  logic [SW-1:0]    quo_signed;
  logic             quo_neg;

  assign sx = in_tdata[CB-1:0];
  assign sy = in_tdata[2*CB-1:CB];
  assign ex = in_tdata[3*CB-1:2*CB];
  assign ey = in_tdata[4*CB-1:3*CB];

  assign in_tready = (state_r == ddalr_pkg::ST_IDLE) && (!ovalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    dx    = {1'b0, ex} - {1'b0, sx};
    dy    = {1'b0, ey} - {1'b0, sy};
    adx   = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    ady   = dy[CB] ? CB'(-dy) : dy[CB-1:0];
    steps = (adx > ady) ? adx : ady;
    x_sum = x_acc_r + {{(AW-SW){x_step_r[SW-1]}}, x_step_r};
    y_sum = y_acc_r + {{(AW-SW){y_step_r[SW-1]}}, y_step_r};
    x_rnd = x_sum + (AW'(1) << (FB - 1));
    y_rnd = y_sum + (AW'(1) << (FB - 1));
  end

  always_comb begin
    quo_neg    = (state_r == ddalr_pkg::ST_DIV_X) ? xneg_r : yneg_r;
    quo_signed = quo_neg ? SW'(-{1'b0, quo}) : {1'b0, quo};
  end

  ddalr_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (quo)
  );

  always_comb begin
    state_nxt      = state_r;
    x_acc_nxt      = x_acc_r;
    y_acc_nxt      = y_acc_r;
    x_step_nxt     = x_step_r;
    y_step_nxt     = y_step_r;
    steps_left_nxt = steps_left_r;
    active_nxt     = active_r;
    ady_nxt        = ady_r;
    xneg_nxt       = xneg_r;
    yneg_nxt       = yneg_r;
    ovalid_nxt     = ovalid_r && !out_tready;
    px_nxt         = px_r;
    py_nxt         = py_r;
    last_nxt       = last_r;
    none_nxt       = none_r;
    div_start      = 1'b0;
    div_num        = {adx, FB'(0)};
    div_den        = steps;

    unique case (state_r)
      ddalr_pkg::ST_IDLE: begin
        if (accept) begin
          ovalid_nxt = 1'b1;
          if (in_tuser[0] == ddalr_pkg::OP_START) begin
            x_acc_nxt      = {1'b0, sx, FB'(0)};
            y_acc_nxt      = {1'b0, sy, FB'(0)};
            px_nxt         = sx;
            py_nxt         = sy;
            none_nxt       = 1'b0;
            steps_left_nxt = steps;
            ady_nxt        = ady;
            xneg_nxt       = dx[CB];
            yneg_nxt       = dy[CB];
            if (steps == '0) begin
              last_nxt   = 1'b1;
              active_nxt = 1'b0;
              x_step_nxt = '0;
              y_step_nxt = '0;
            end else begin
              last_nxt      = 1'b0;
              active_nxt    = 1'b1;
              div_start     = 1'b1;
              state_nxt     = ddalr_pkg::ST_DIV_X;
            end
          end else if (!active_r) begin
            px_nxt   = '0;
            py_nxt   = '0;
            last_nxt = 1'b0;
            none_nxt = 1'b1;
          end else begin
            x_acc_nxt      = x_sum;
            y_acc_nxt      = y_sum;
            steps_left_nxt = steps_left_r - CB'(1);
            px_nxt         = x_rnd[CB+FB-1:FB];
            py_nxt         = y_rnd[CB+FB-1:FB];
            none_nxt       = 1'b0;
            last_nxt       = (steps_left_r == CB'(1));
            active_nxt     = (steps_left_r != CB'(1));
          end
        end
      end
      ddalr_pkg::ST_DIV_X: begin
        div_num = {ady_r, FB'(0)};
        div_den = steps_left_r;
        if (div_done) begin
          x_step_nxt    = quo_signed;
          div_start     = 1'b1;
          state_nxt     = ddalr_pkg::ST_DIV_Y;
        end
      end
      ddalr_pkg::ST_DIV_Y: begin
        if (div_done) begin
          y_step_nxt = quo_signed;
          state_nxt  = ddalr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ddalr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ady_r  <= ady_nxt;
    xneg_r <= xneg_nxt;
    yneg_r <= yneg_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
    none_r <= none_nxt;
    if (!rst_n) begin
      state_r      <= ddalr_pkg::ST_IDLE;
      x_acc_r      <= '0;
      y_acc_r      <= '0;
      x_step_r     <= '0;
      y_step_r     <= '0;
      steps_left_r <= '0;
      active_r     <= 1'b0;
      ovalid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      x_acc_r      <= x_acc_nxt;
      y_acc_r      <= y_acc_nxt;
      x_step_r     <= x_step_nxt;
      y_step_r     <= y_step_nxt;
      steps_left_r <= steps_left_nxt;
      active_r     <= active_nxt;
      ovalid_r     <= ovalid_nxt;
    end
  end

  assign out_tvalid   = ovalid_r;
  assign out_tdata    = OUT_W'({py_r, px_r});
  assign out_tlast    = last_r;
  assign out_tuser[0] = none_r;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// self-checking stream testbench for the dda line rasterizer
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD = 10;
  localparam int FRAC = 16;
  localparam int HALF = 1 << (FRAC - 1);
  localparam int COORD_MAX = (1 << COORD) - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 2 * (COORD + FRAC) + 10;

  typedef struct packed {
    logic [COORD-1:0] px;
    logic [COORD-1:0] py;
    logic last;
    logic none;
  } point_t;

  typedef struct {
    ddalr_pkg::op_t op;
    logic [COORD-1:0] sx;
    logic [COORD-1:0] sy;
    logic [COORD-1:0] ex;
    logic [COORD-1:0] ey;
    bit pause;
  } line_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic out_tlast;
  logic [0:0] out_tuser;

  dda_line_rasterizer #(.COORD_BITS(COORD), .FRAC_BITS(FRAC)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_item_t line_q[$];
  point_t point_q[$];
  int fail_cnt = 0;
  int cycle_cnt = 0;
  bit no_idle = 1'b0;

  // line state mirrored at the block's accumulator and step widths
  logic signed [26:0] acc_x = '0;
  logic signed [26:0] acc_y = '0;
  logic signed [17:0] inc_x = '0;
  logic signed [17:0] inc_y = '0;
  logic [10:0] steps_rem = '0;
  bit line_on = 1'b0;

  function automatic logic [COORD-1:0] round_half_up(logic signed [26:0] acc);
    logic signed [27:0] t;
    t = acc;
    t = t + 28'(HALF);
    return t[FRAC+COORD-1:FRAC];
  endfunction

  function automatic point_t predict_point(line_item_t it);
    point_t p;
    longint dx, dy, adx, ady, span;
    p = '0;
    if (it.op == ddalr_pkg::OP_START) begin
      dx = longint'(it.ex);
      dx = dx - longint'(it.sx);
      dy = longint'(it.ey);
      dy = dy - longint'(it.sy);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      span = adx > ady ? adx : ady;
      acc_x = $signed({1'b0, it.sx, {FRAC{1'b0}}});
      acc_y = $signed({1'b0, it.sy, {FRAC{1'b0}}});
      if (span == 0) begin
        inc_x = '0;
        inc_y = '0;
        steps_rem = '0;
        line_on = 1'b0;
      end else begin
        inc_x = 18'((dx * (longint'(1) << FRAC)) / span);
        inc_y = 18'((dy * (longint'(1) << FRAC)) / span);
        steps_rem = 11'(span);
        line_on = 1'b1;
      end
      p.px = it.sx;
      p.py = it.sy;
      p.last = !line_on;
    end else if (line_on) begin
      acc_x = acc_x + inc_x;
      acc_y = acc_y + inc_y;
      steps_rem = steps_rem - 1'b1;
      if (steps_rem == 0) line_on = 1'b0;
      p.px = round_half_up(acc_x);
      p.py = round_half_up(acc_y);
      p.last = !line_on;
    end else begin
      p.none = 1'b1;
    end
    return p;
  endfunction

  // driver
  line_item_t cur;
  bit have_item = 1'b0;
  bit sending;
  bit launch;
  int gap_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      have_item = 1'b0;
    end else begin
      sending = in_tvalid;
      if (in_tvalid && in_tready) begin
        point_q.push_back(predict_point(cur));
        sending = 1'b0;
        have_item = 1'b0;
      end
      if (!sending) begin
        if (!have_item && line_q.size() != 0) begin
          cur = line_q.pop_front();
          have_item = 1'b1;
          if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
          gap_cnt = no_idle ? 0 : $urandom_range(0, 12);
        end
        launch = have_item && gap_cnt == 0 && (!cur.pause || point_q.size() == 0);
        if (!launch && gap_cnt > 0) gap_cnt--;
        in_tvalid <= launch;
        if (launch) begin
          in_tdata <= {cur.ey, cur.ex, cur.sy, cur.sx};
          in_tuser <= cur.op;
        end
      end
    end
  end

  // monitor
  point_t got;
  point_t want;
  int hold_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt = 0;
    end else if (out_tvalid && out_tready) begin
      got.px = out_tdata[COORD-1:0];
      got.py = out_tdata[2*COORD-1:COORD];
      got.last = out_tlast;
      got.none = out_tuser[0];
      if (point_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected point: px=%0d py=%0d last=%0b none=%0b",
                   got.px, got.py, got.last, got.none);
      end else begin
        want = point_q.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("point mismatch: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                     want.px, want.py, want.last, want.none,
                     got.px, got.py, got.last, got.none);
        end
      end
      hold_cnt = no_idle ? 0 : $urandom_range(0, 12);
      out_tready <= (hold_cnt == 0);
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= (hold_cnt == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_item(ddalr_pkg::op_t op, int sx, int sy, int ex, int ey,
                           bit pause = 1'b0);
    line_item_t it;
    it.op = op;
    it.sx = COORD'(sx);
    it.sy = COORD'(sy);
    it.ex = COORD'(ex);
    it.ey = COORD'(ey);
    it.pause = pause;
    line_q.push_back(it);
  endtask

  task automatic push_steps(int n);
    for (int i = 0; i < n; i++)
      push_item(ddalr_pkg::OP_STEP, $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
  endtask

  function automatic int clamp_coord(int v);
    return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
  endfunction

  function automatic int abs_i(int v);
    return v < 0 ? -v : v;
  endfunction

  int total;
  int sx, sy, ex, ey, span, n, pick;

  initial begin
    // step with no line after reset
    push_item(ddalr_pkg::OP_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    // full diagonal, dropped after two steps by a new start
    push_item(ddalr_pkg::OP_START, 0, 0, COORD_MAX, COORD_MAX);
    push_steps(2);
    push_item(ddalr_pkg::OP_START, COORD_MAX, 0, 0, COORD_MAX);
    push_steps(2);
    // equal endpoints, then a step with nothing active
    push_item(ddalr_pkg::OP_START, 5, 5, 5, 5);
    push_steps(1);
    // short run to its last point and one past it
    push_item(ddalr_pkg::OP_START, 0, COORD_MAX, 3, COORD_MAX, 1'b1);
    push_steps(4);
    // y-major with a negative x increment
    push_item(ddalr_pkg::OP_START, 10, 10, 7, 14);
    push_steps(4);
    // half-pixel increments exercise round half up
    push_item(ddalr_pkg::OP_START, 0, 0, 1, 2);
    push_steps(2);
    push_item(ddalr_pkg::OP_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);

    total = line_q.size();
    while (total < 400) begin
      pick = $urandom_range(0, 99);
      sx = $urandom_range(0, COORD_MAX);
      sy = $urandom_range(0, COORD_MAX);
      if (pick < 65) begin
        span = ($urandom_range(0, 19) == 0) ? 150 : 15;
        ex = clamp_coord(sx + $urandom_range(0, 2 * span) - span);
        ey = clamp_coord(sy + $urandom_range(0, 2 * span) - span);
        n = abs_i(ex - sx) > abs_i(ey - sy) ? abs_i(ex - sx) : abs_i(ey - sy);
        if ($urandom_range(0, 3) == 0) n++;
        push_item(ddalr_pkg::OP_START, sx, sy, ex, ey, $urandom_range(0, 29) == 0);
        push_steps(n);
        total += n + 1;
      end else if (pick < 80) begin
        n = $urandom_range(0, 4);
        push_item(ddalr_pkg::OP_START, sx, sy, $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX));
        push_steps(n);
        total += n + 1;
      end else if (pick < 90) begin
        push_item(ddalr_pkg::OP_START, sx, sy, sx, sy);
        total++;
      end else begin
        push_steps(1);
        total++;
      end
    end

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (line_q.size() != 0 || have_item || in_tvalid || point_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (point_q.size() != 0) begin
      fail_cnt++;
      $display("%0d expected points never arrived", point_q.size());
    end
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ddalr_pkg.sv
rtl/ddalr_div.sv
rtl/dda_line_rasterizer.sv
bench/tb_top.sv
